@@ hdl/cicd_pkg.sv @@
// Shared types, constants and field widths for the cloud-in-cell charge deposit block.
package cicd_pkg;

  localparam int GRID_X_DEF = 32;
  localparam int GRID_Y_DEF = 32;

  localparam int POS_W  = 26;
  localparam int INV_W  = 24;
  localparam int Q_W    = 32;
  localparam int IDX_W  = 5;
  localparam int SUM_W  = 48;
  localparam int WGT_W  = 17;
  localparam int U_W    = 34;
  localparam int NODE_W = 19;

  localparam int S_DATA_W = 96;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 48;
  localparam int M_USER_W = 1;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = 67;

  localparam logic [INV_W-1:0] INV_RESET = 24'h010000;
  localparam logic [WGT_W-1:0] ONE_Q16   = 17'h10000;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_DEPOSIT = 2'd1,
    REQ_READ    = 2'd2
  } req_e;

  typedef enum logic {
    REG_X_INV = 1'b0,
    REG_Y_INV = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_MX,
    ST_MY,
    ST_CHK,
    ST_MW,
    ST_MQ,
    ST_WR,
    ST_RD,
    ST_RDW,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [WGT_W-1:0]  wgt;
  } axis_t;

  typedef struct packed {
    logic busy;
    logic clearing;
    logic ram_we;
  } seq_stat_t;

endpackage

@@ hdl/cicd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cicd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/cicd_mul.sv @@
// Shared registered multiplier: unsigned by signed operand, one product per cycle.
module cicd_mul (
  input  logic                                 clk_i,
  input  logic [cicd_pkg::MUL_A_W-1:0]         a_i,
  input  logic signed [cicd_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [cicd_pkg::MUL_P_W-1:0]  p_o
);
  import cicd_pkg::*;

  logic signed [MUL_P_W-1:0] p_d;
  logic signed [MUL_P_W-1:0] p_q;

  assign p_d = MUL_P_W'($signed({1'b0, a_i})) * MUL_P_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

@@ hdl/cicd_seq.sv @@
// Request sequencer: scaling, range check, four read-modify-write updates, reads and clears.
module cicd_seq #(
  parameter int GRID_X = cicd_pkg::GRID_X_DEF,
  parameter int GRID_Y = cicd_pkg::GRID_Y_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  logic [cicd_pkg::S_DATA_W-1:0]             s_axis_tdata,
  input  logic [cicd_pkg::S_USER_W-1:0]             s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  output logic [cicd_pkg::M_DATA_W-1:0]             m_axis_tdata,
  output logic [cicd_pkg::M_USER_W-1:0]             m_axis_tuser,
  input  logic [cicd_pkg::INV_W-1:0]                x_inv_i,
  input  logic [cicd_pkg::INV_W-1:0]                y_inv_i,
  output logic [cicd_pkg::MUL_A_W-1:0]              mul_a_o,
  output logic signed [cicd_pkg::MUL_B_W-1:0]       mul_b_o,
  input  logic signed [cicd_pkg::MUL_P_W-1:0]       mul_p_i,
  output logic                                      ram_we_o,
  output logic [$clog2(GRID_X*GRID_Y)-1:0]          ram_waddr_o,
  output logic [cicd_pkg::SUM_W-1:0]                ram_wdata_o,
  output logic                                      ram_re_o,
  output logic [$clog2(GRID_X*GRID_Y)-1:0]          ram_raddr_o,
  input  logic [cicd_pkg::SUM_W-1:0]                ram_rdata_i,
  output cicd_pkg::seq_stat_t                       stat_o
);
  import cicd_pkg::*;

  localparam int N  = GRID_X * GRID_Y;
  localparam int AW = $clog2(N);
  localparam int XW = $clog2(GRID_X);
  localparam int YW = $clog2(GRID_Y);
  localparam logic [NODE_W-1:0] XMAX = NODE_W'(GRID_X - 1);
  localparam logic [NODE_W-1:0] YMAX = NODE_W'(GRID_Y - 1);
  localparam logic [AW-1:0]     LAST = AW'(N - 1);

  function automatic axis_t axis_split(input logic [MUL_P_W-1:0] p);
    logic [U_W-1:0] u;
    logic           frac_nz;
    axis_t          r;
    u       = p[U_W+15:16];
    frac_nz = |u[15:0];
    r.node  = NODE_W'(u[U_W-1:16]) + NODE_W'(frac_nz);
    if (r.node == '0) begin
      r.wgt = '0;
    end else if (frac_nz) begin
      r.wgt = {1'b0, u[15:0]};
    end else begin
      r.wgt = ONE_Q16;
    end
    return r;
  endfunction

  state_e state_q, state_d;
  logic [POS_W-1:0]        pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [Q_W-1:0]   q_q, q_d;
  logic [IDX_W-1:0]        col_q, col_d, row_q, row_d;
  logic [AW-1:0]           cnt_q, cnt_d;
  logic [1:0]              corner_q, corner_d;
  logic                    clr_resp_q, clr_resp_d;
  logic                    hit_q, hit_d;
  logic [NODE_W-1:0]       cx_q, cx_d;
  logic [YW-1:0]           cy_q, cy_d;
  logic [WGT_W-1:0]        wx_q, wx_d, wy_q, wy_d;
  logic                    res_status_q, res_status_d;
  logic [SUM_W-1:0]        res_density_q, res_density_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_status_q, out_status_d;
  logic [SUM_W-1:0]        out_density_q, out_density_d;

  axis_t                   ax, ay;
  logic [XW-1:0]           xsel;
  logic [YW-1:0]           ysel;
  logic [WGT_W-1:0]        wsx, wsy;
  logic [AW-1:0]           corner_addr, read_addr;
  logic                    read_ok;
  logic signed [Q_W-1:0]   share;
  logic [SUM_W:0]          sum;
  logic [SUM_W-1:0]        sum_sat;

  assign ax = axis_split(mul_p_i);
  assign ay = axis_split(mul_p_i);

  assign xsel = corner_q[0] ? (cx_q[XW-1:0] - XW'(1)) : cx_q[XW-1:0];
  assign ysel = corner_q[1] ? (cy_q - YW'(1)) : cy_q;
  assign wsx  = corner_q[0] ? (ONE_Q16 - wx_q) : wx_q;
  assign wsy  = corner_q[1] ? (ONE_Q16 - wy_q) : wy_q;
  assign corner_addr = AW'(AW'(ysel) * AW'(GRID_X)) + AW'(xsel);
  assign read_addr   = AW'(AW'(row_q) * AW'(GRID_X)) + AW'(col_q);
  assign read_ok     = (32'(col_q) < GRID_X) && (32'(row_q) < GRID_Y);

  assign share = $signed(mul_p_i[63:32]);
  assign sum   = {ram_rdata_i[SUM_W-1], ram_rdata_i} + (SUM_W+1)'(share);
  always_comb begin
    if (sum[SUM_W] != sum[SUM_W-1]) begin
      sum_sat = sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum[SUM_W-1:0];
    end
  end

  always_comb begin
    state_d       = state_q;
    pos_x_d       = pos_x_q;
    pos_y_d       = pos_y_q;
    q_d           = q_q;
    col_d         = col_q;
    row_d         = row_q;
    cnt_d         = cnt_q;
    corner_d      = corner_q;
    clr_resp_d    = clr_resp_q;
    hit_d         = hit_q;
    cx_d          = cx_q;
    cy_d          = cy_q;
    wx_d          = wx_q;
    wy_d          = wy_q;
    res_status_d  = res_status_q;
    res_density_d = res_density_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_status_d  = out_status_q;
    out_density_d = out_density_q;
    mul_a_o       = '0;
    mul_b_o       = '0;
    ram_we_o      = 1'b0;
    ram_waddr_o   = corner_addr;
    ram_wdata_o   = sum_sat;
    ram_re_o      = 1'b0;
    ram_raddr_o   = corner_addr;
    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_CLR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q;
        ram_wdata_o = '0;
        cnt_d       = cnt_q + AW'(1);
        if (cnt_q == LAST) begin
          cnt_d   = '0;
          state_d = clr_resp_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          pos_x_d       = s_axis_tdata[25:0];
          pos_y_d       = s_axis_tdata[51:26];
          q_d           = $signed(s_axis_tdata[83:52]);
          col_d         = s_axis_tdata[88:84];
          row_d         = s_axis_tdata[93:89];
          res_status_d  = 1'b0;
          res_density_d = '0;
          corner_d      = '0;
          unique case (req_e'(s_axis_tuser))
            REQ_CLEAR: begin
              clr_resp_d = 1'b1;
              cnt_d      = '0;
              state_d    = ST_CLR;
            end
            REQ_DEPOSIT: state_d = ST_MX;
            REQ_READ:    state_d = ST_RD;
            default:     state_d = ST_RESP;
          endcase
        end
      end
      ST_MX: begin
        mul_a_o = MUL_A_W'(pos_x_q);
        mul_b_o = MUL_B_W'(x_inv_i);
        state_d = ST_MY;
      end
      ST_MY: begin
        mul_a_o = MUL_A_W'(pos_y_q);
        mul_b_o = MUL_B_W'(y_inv_i);
        cx_d    = ax.node;
        wx_d    = ax.wgt;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        cy_d = ay.node[YW-1:0];
        wy_d = ay.wgt;
        if (cx_q == '0 || cx_q > XMAX || ay.node == '0 || ay.node > YMAX) begin
          res_status_d = 1'b1;
          state_d      = ST_RESP;
        end else begin
          state_d = ST_MW;
        end
      end
      ST_MW: begin
        mul_a_o  = MUL_A_W'(wsx);
        mul_b_o  = MUL_B_W'(wsy);
        ram_re_o = 1'b1;
        state_d  = ST_MQ;
      end
      ST_MQ: begin
        mul_a_o = mul_p_i[MUL_A_W-1:0];
        mul_b_o = MUL_B_W'(q_q);
        state_d = ST_WR;
      end
      ST_WR: begin
        ram_we_o = 1'b1;
        corner_d = corner_q + 2'd1;
        state_d  = (corner_q == 2'd3) ? ST_RESP : ST_MW;
      end
      ST_RD: begin
        ram_re_o    = read_ok;
        ram_raddr_o = read_addr;
        hit_d       = read_ok;
        state_d     = ST_RDW;
      end
      ST_RDW: begin
        res_density_d = hit_q ? ram_rdata_i : '0;
        state_d       = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d   = 1'b1;
          out_status_d  = res_status_q;
          out_density_d = res_density_q;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cnt_q       <= '0;
      corner_q    <= '0;
      clr_resp_q  <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      corner_q    <= corner_d;
      clr_resp_q  <= clr_resp_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_q       <= pos_x_d;
    pos_y_q       <= pos_y_d;
    q_q           <= q_d;
    col_q         <= col_d;
    row_q         <= row_d;
    cx_q          <= cx_d;
    cy_q          <= cy_d;
    wx_q          <= wx_d;
    wy_q          <= wy_d;
    res_status_q  <= res_status_d;
    res_density_q <= res_density_d;
    out_status_q  <= out_status_d;
    out_density_q <= out_density_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_density_q;
  assign m_axis_tuser    = out_status_q;
  assign stat_o.busy     = (state_q != ST_IDLE);
  assign stat_o.clearing = (state_q == ST_CLR);
  assign stat_o.ram_we   = ram_we_o;

endmodule

@@ hdl/cic_charge_deposit_2d.sv @@
// Top level of the 2D cloud-in-cell charge deposit block: register port, sequencer, grid memory.
//
// Channel   Direction  Handshake                 Contents
// s_axis    in         tvalid/tready             request word: kind in tuser, operands in tdata
// m_axis    out        tvalid/tready             result word: status in tuser, density in tdata
// apb       in/out     psel/penable/pwrite       inverse cell sizes, pready always high
//
// A deposit passes ST_MX, ST_MY, ST_CHK and then ST_MW, ST_MQ, ST_WR per node, a dropped deposit
// stops after ST_CHK, a read passes ST_RD and ST_RDW, an unused request goes straight to ST_RESP
// and a clear sweeps all nodes; a deposit's read-modify-write per node uses one shared multiplier
// and a single memory. After reset the grid memory is swept to zero with s_axis_tready low.
// One request is in flight at a time; a stalled result holds the sequencer until taken.
module cic_charge_deposit_2d #(
  parameter int GRID_X = cicd_pkg::GRID_X_DEF,
  parameter int GRID_Y = cicd_pkg::GRID_Y_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x[25:0], pos_y[51:26], charge[83:52], read_col[88:84], read_row[93:89], zero[95:94]
  input  logic [cicd_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // req_type[1:0]
  input  logic [cicd_pkg::S_USER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // density[47:0]
  output logic [cicd_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // status[0]
  output logic [cicd_pkg::M_USER_W-1:0]   m_axis_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cicd_pkg::CFG_AW-1:0]     paddr,
  input  logic [cicd_pkg::CFG_DW-1:0]     pwdata,
  output logic [cicd_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready
);
  import cicd_pkg::*;

  localparam int AW = $clog2(GRID_X * GRID_Y);

  logic [INV_W-1:0]          x_inv_q, x_inv_d, y_inv_q, y_inv_d;
  reg_e                      reg_sel;
  logic                      cfg_wr;
  logic [MUL_A_W-1:0]        mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [SUM_W-1:0]          ram_wdata, ram_rdata;
  seq_stat_t                 stat;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    x_inv_d = x_inv_q;
    y_inv_d = y_inv_q;
    prdata  = '0;
    unique case (reg_sel)
      REG_X_INV: begin
        prdata = CFG_DW'(x_inv_q);
        if (cfg_wr) begin
          x_inv_d = pwdata[INV_W-1:0];
        end
      end
      REG_Y_INV: begin
        prdata = CFG_DW'(y_inv_q);
        if (cfg_wr) begin
          y_inv_d = pwdata[INV_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_inv_q <= INV_RESET;
      y_inv_q <= INV_RESET;
    end else begin
      x_inv_q <= x_inv_d;
      y_inv_q <= y_inv_d;
    end
  end

  cicd_seq #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .x_inv_i      (x_inv_q),
    .y_inv_i      (y_inv_q),
    .mul_a_o      (mul_a),
    .mul_b_o      (mul_b),
    .mul_p_i      (mul_p),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .stat_o       (stat)
  );

  cicd_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  cicd_ram #(
    .WIDTH(SUM_W),
    .DEPTH(GRID_X * GRID_Y)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !s_axis_tready)
    else $error("Request word accepted during the grid clearing pass.");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && stat.busy))
    else $error("Sequencer did not start work on an accepted request word.");

  a_write_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.ram_we |-> stat.busy)
    else $error("Grid memory written while the sequencer is idle.");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(stat.busy))
    else $error("Result word appeared without a request in progress.");

endmodule

@@ tb/cic_charge_deposit_2d_checker.sv @@
// Checker for the charge deposit block: watches the request, result and register ports.
module cic_charge_deposit_2d_checker #(
  parameter int GRID_X = cicd_pkg::GRID_X_DEF,
  parameter int GRID_Y = cicd_pkg::GRID_Y_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // pos_x[25:0], pos_y[51:26], charge[83:52], read_col[88:84], read_row[93:89], zero[95:94]
  input  logic [cicd_pkg::S_DATA_W-1:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [cicd_pkg::S_USER_W-1:0] s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // density[47:0]
  input  logic [cicd_pkg::M_DATA_W-1:0] m_axis_tdata,
  // status[0]
  input  logic [cicd_pkg::M_USER_W-1:0] m_axis_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cicd_pkg::CFG_AW-1:0]   paddr,
  input  logic [cicd_pkg::CFG_DW-1:0]   pwdata,
  input  logic [cicd_pkg::CFG_DW-1:0]   prdata,
  input  logic                          pready,
  output int                            fail_count_o,
  output int                            owed_o,
  output int                            placed_o,
  output int                            dropped_o,
  output int                            reads_o,
  output int                            nonzero_reads_o,
  output int                            clears_o,
  output int                            reg_writes_o
);
  import cicd_pkg::*;

  localparam int Y_LSB   = POS_W;
  localparam int Q_LSB   = 2 * POS_W;
  localparam int COL_LSB = Q_LSB + Q_W;
  localparam int ROW_LSB = COL_LSB + IDX_W;

  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct packed {
    logic             status;
    logic [SUM_W-1:0] density;
  } outcome_t;

  longint           charge_sum [GRID_X*GRID_Y];
  logic [INV_W-1:0] x_step;
  logic [INV_W-1:0] y_step;
  outcome_t         owed_q [$];
  outcome_t         due;
  logic [IDX_W-1:0] col;
  logic [IDX_W-1:0] row;
  longint           node_sum;
  logic [INV_W-1:0] step_now;

  initial begin
    fail_count_o    = 0;
    owed_o          = 0;
    placed_o        = 0;
    dropped_o       = 0;
    reads_o         = 0;
    nonzero_reads_o = 0;
    clears_o        = 0;
    reg_writes_o    = 0;
  end

  // Printing stops after the first hundred mismatches; all of them are counted.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count_o < 100) begin
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    fail_count_o++;
  endtask

  // Scales one coordinate to grid units and gives the upper node and its Q.16 weight.
  function automatic void scale_axis(input logic [POS_W-1:0] pos, input logic [INV_W-1:0] inv,
                                     output logic [NODE_W-1:0] node,
                                     output logic [WGT_W-1:0] wgt);
    logic [POS_W+INV_W-1:0] prod;
    logic [U_W-1:0]         u;
    logic [U_W:0]           up;
    prod = {{INV_W{1'b0}}, pos} * {{POS_W{1'b0}}, inv};
    u    = prod[POS_W+INV_W-1:16];
    up   = u + 16'hFFFF;
    node = up[U_W:16];
    if (node == '0) begin
      wgt = '0;
    end else begin
      wgt = WGT_W'(u - {(node - 1'b1), 16'h0000});
    end
  endfunction

  function automatic void add_share(input int idx, input logic [WGT_W-1:0] wa,
                                    input logic [WGT_W-1:0] wb,
                                    input logic signed [Q_W-1:0] q);
    logic [2*WGT_W-1:0] wprod;
    longint             prod;
    longint             total;
    wprod = wa * wb;
    prod  = $signed({30'b0, wprod}) * longint'(q);
    total = charge_sum[idx] + (prod >>> 32);
    if (total > SUM_MAX) begin
      total = SUM_MAX;
    end else if (total < SUM_MIN) begin
      total = SUM_MIN;
    end
    charge_sum[idx] = total;
  endfunction

  // Spreads one particle over its four nodes; returns the dropped flag.
  function automatic logic place_charge(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                                        input logic signed [Q_W-1:0] q);
    logic [NODE_W-1:0] cx;
    logic [NODE_W-1:0] cy;
    logic [WGT_W-1:0]  wx;
    logic [WGT_W-1:0]  wy;
    int                ix;
    int                iy;
    scale_axis(px, x_step, cx, wx);
    scale_axis(py, y_step, cy, wy);
    if (cx < 1 || cx > GRID_X - 1 || cy < 1 || cy > GRID_Y - 1) begin
      return 1'b1;
    end
    ix = int'(cx);
    iy = int'(cy);
    add_share(iy * GRID_X + ix, wx, wy, q);
    add_share(iy * GRID_X + ix - 1, ONE_Q16 - wx, wy, q);
    add_share((iy - 1) * GRID_X + ix, wx, ONE_Q16 - wy, q);
    add_share((iy - 1) * GRID_X + ix - 1, ONE_Q16 - wx, ONE_Q16 - wy, q);
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_step = INV_RESET;
      y_step = INV_RESET;
      foreach (charge_sum[i]) charge_sum[i] = 0;
      owed_q.delete();
      owed_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("result word with nothing pending", m_axis_tdata, 0);
        end else begin
          due = owed_q.pop_front();
          if (m_axis_tuser[0] !== due.status) begin
            report_mismatch("status", m_axis_tuser[0], due.status);
          end
          if (m_axis_tdata !== due.density) begin
            report_mismatch("density", m_axis_tdata, due.density);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        due = '0;
        case (s_axis_tuser)
          REQ_CLEAR: begin
            foreach (charge_sum[i]) charge_sum[i] = 0;
            clears_o++;
          end
          REQ_DEPOSIT: begin
            due.status = place_charge(s_axis_tdata[POS_W-1:0], s_axis_tdata[Y_LSB +: POS_W],
                                      s_axis_tdata[Q_LSB +: Q_W]);
            if (due.status) begin
              dropped_o++;
            end else begin
              placed_o++;
            end
          end
          REQ_READ: begin
            col = s_axis_tdata[COL_LSB +: IDX_W];
            row = s_axis_tdata[ROW_LSB +: IDX_W];
            if (col < GRID_X && row < GRID_Y) begin
              node_sum    = charge_sum[row * GRID_X + col];
              due.density = node_sum[SUM_W-1:0];
            end
            reads_o++;
            if (due.density != '0) begin
              nonzero_reads_o++;
            end
          end
          default: ;
        endcase
        owed_q.push_back(due);
      end

      if (psel && penable && pready && paddr[1:0] == 2'b00) begin
        if (pwrite) begin
          case (reg_e'(paddr[CFG_AW-1:2]))
            REG_X_INV: x_step = pwdata[INV_W-1:0];
            REG_Y_INV: y_step = pwdata[INV_W-1:0];
            default: ;
          endcase
          reg_writes_o++;
        end else begin
          step_now = (reg_e'(paddr[CFG_AW-1:2]) == REG_X_INV) ? x_step : y_step;
          if (prdata !== CFG_DW'(step_now)) begin
            report_mismatch("register read", prdata, step_now);
          end
        end
      end

      owed_o = owed_q.size();
    end
  end

endmodule

@@ tb/tb_cic_charge_deposit_2d.sv @@
// Testbench top for the charge deposit block: clock, reset, stimulus and verdict.
module tb_cic_charge_deposit_2d;
  import cicd_pkg::*;

  localparam int GRID_X = GRID_X_DEF;
  localparam int GRID_Y = GRID_Y_DEF;

  localparam logic [S_USER_W-1:0] REQ_SPARE = 2'd3;
  localparam logic [Q_W-1:0]      Q_ONE     = 32'h0001_0000;
  localparam logic [INV_W-1:0]    INV_MAX   = 24'hFF_FFFF;

  localparam int PHASES           = 6;
  localparam int WORDS_PER_PHASE  = 317;
  localparam int LONG_HOLD_AT     = 700;
  localparam int LONG_HOLD_CYCLES = 600;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // pos_x[25:0], pos_y[51:26], charge[83:52], read_col[88:84], read_row[93:89], zero[95:94]
  logic [S_DATA_W-1:0] s_axis_tdata;
  // req_type[1:0]
  logic [S_USER_W-1:0] s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // density[47:0]
  logic [M_DATA_W-1:0] m_axis_tdata;
  // status[0]
  logic [M_USER_W-1:0] m_axis_tuser;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  int fail_count;
  int owed;
  int placed;
  int dropped;
  int reads;
  int nonzero_reads;
  int clears;
  int reg_writes;

  logic [INV_W-1:0] x_step;
  logic [INV_W-1:0] y_step;
  bit               no_gaps = 1'b0;
  bit               long_hold_done = 1'b0;
  int               sent_words = 0;
  int               last_cx = 1;
  int               last_cy = 1;

  cic_charge_deposit_2d #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  cic_charge_deposit_2d_checker #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count_o    (fail_count),
    .owed_o          (owed),
    .placed_o        (placed),
    .dropped_o       (dropped),
    .reads_o         (reads),
    .nonzero_reads_o (nonzero_reads),
    .clears_o        (clears),
    .reg_writes_o    (reg_writes)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("cic_charge_deposit_2d verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sent_words <= sent_words + 1;
  end

  // Result side: random stalls, changing acceptance rate, and one long hold-off.
  initial begin
    int stall_left;
    int pct;
    int tick;
    stall_left    = 0;
    pct           = 100;
    tick          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (tick % 128 == 0) begin
        case ($urandom_range(0, 3))
          0: pct = 100;
          1: pct = 90;
          2: pct = 60;
          default: pct = 30;
        endcase
      end
      if (!long_hold_done && sent_words >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        if ($urandom_range(0, 99) < 2) stall_left = $urandom_range(8, 40);
        m_axis_tready <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  task automatic send_word(input logic [S_USER_W-1:0] kind, input logic [POS_W-1:0] px,
                           input logic [POS_W-1:0] py, input logic [Q_W-1:0] q,
                           input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
    int gap;
    int r;
    gap = 0;
    if (!no_gaps) begin
      r = $urandom_range(0, 99);
      if (r >= 98) begin
        gap = $urandom_range(20, 60);
      end else if (r >= 90) begin
        gap = $urandom_range(4, 12);
      end else if (r >= 45) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, row, col, q, py, px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stops offering words and waits until every pending result has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (owed != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes one inverse cell size register and reads it back.
  task automatic set_step(input reg_e idx, input logic [INV_W-1:0] value);
    logic [CFG_DW-INV_W-1:0] junk;
    junk = (CFG_DW-INV_W)'($urandom);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_X_INV) begin
      x_step = value;
    end else begin
      y_step = value;
    end
  endtask

  // Picks a position whose scaled value lands inside the grid on this axis, or any position when inv is zero.
  function automatic logic [POS_W-1:0] aim_pos(input logic [INV_W-1:0] inv, input int top_node,
                                               output int node);
    longint target;
    longint pos;
    node = 0;
    if (inv == '0) return POS_W'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      target = longint'($urandom_range(1, top_node)) << 16;
    end else begin
      target = $urandom_range(1, (top_node << 16) - 512);
    end
    node = int'((target + 65535) >> 16);
    pos  = ((target << 16) + inv - 1) / inv;
    if (pos > 64'h3FF_FFFF) pos = 64'h3FF_FFFF;
    return POS_W'(pos);
  endfunction

  task automatic random_word();
    logic [S_USER_W-1:0] kind;
    logic [POS_W-1:0]    px;
    logic [POS_W-1:0]    py;
    logic [Q_W-1:0]      q;
    logic [IDX_W-1:0]    col;
    logic [IDX_W-1:0]    row;
    int                  pick;
    px   = POS_W'($urandom);
    py   = POS_W'($urandom);
    q    = $urandom;
    col  = IDX_W'($urandom);
    row  = IDX_W'($urandom);
    pick = $urandom_range(0, 999);
    case ($urandom_range(0, 3))
      0: q = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: q = Q_W'($urandom_range(0, 1 << 21)) - Q_W'(1 << 20);
      default: ;
    endcase
    if (pick < 10) begin
      kind = REQ_CLEAR;
    end else if (pick < 60) begin
      kind = REQ_SPARE;
    end else if (pick < 440) begin
      kind = REQ_READ;
      if ($urandom_range(0, 1) == 0) begin
        col = IDX_W'(last_cx - $urandom_range(0, 1));
        row = IDX_W'(last_cy - $urandom_range(0, 1));
      end
    end else begin
      kind = REQ_DEPOSIT;
      if ($urandom_range(0, 9) < 8) begin
        px = aim_pos(x_step, GRID_X - 1, last_cx);
        py = aim_pos(y_step, GRID_Y - 1, last_cy);
      end
    end
    send_word(kind, px, py, q, col, row);
  endtask

  initial begin
    logic [INV_W-1:0] xs;
    logic [INV_W-1:0] ys;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    x_step        = INV_RESET;
    y_step        = INV_RESET;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_word(REQ_READ, '0, '0, '0, 5'd0, 5'd0);
    send_word(REQ_DEPOSIT, 26'h01_8000, 26'h02_4000, Q_ONE, '0, '0);
    send_word(REQ_READ, '0, '0, '0, 5'd2, 5'd3);
    send_word(REQ_READ, '0, '0, '0, 5'd1, 5'd3);
    send_word(REQ_READ, '0, '0, '0, 5'd2, 5'd2);
    send_word(REQ_READ, '0, '0, '0, 5'd1, 5'd2);
    send_word(REQ_DEPOSIT, 26'h03_0000, 26'h01_0000, -Q_ONE, '0, '0);
    send_word(REQ_READ, '0, '0, '0, 5'd3, 5'd1);
    send_word(REQ_READ, '0, '0, '0, 5'd2, 5'd0);
    send_word(REQ_DEPOSIT, '0, 26'h01_8000, Q_ONE, '0, '0);
    send_word(REQ_DEPOSIT, 26'h01_8000, '0, Q_ONE, '0, '0);
    send_word(REQ_DEPOSIT, 26'h1F_0001, 26'h01_8000, Q_ONE, '0, '0);
    send_word(REQ_DEPOSIT, 26'h1F_0000, 26'h1F_0000, 32'h7FFF_FFFF, '0, '0);
    send_word(REQ_DEPOSIT, '1, '1, '1, '1, '1);
    send_word(REQ_DEPOSIT, 26'd1, 26'd1, 32'h8000_0000, '0, '0);
    send_word(REQ_READ, '0, '0, '0, 5'd31, 5'd31);
    send_word(REQ_READ, '0, '0, '0, 5'd0, 5'd0);
    send_word(REQ_SPARE, '1, '1, '1, '1, '1);
    send_word(REQ_READ, '1, '1, '1, 5'd31, 5'd0);
    send_word(REQ_CLEAR, '1, '1, '1, '1, '1);
    send_word(REQ_READ, '0, '0, '0, 5'd2, 5'd3);
    send_word(REQ_READ, '0, '0, '0, 5'd31, 5'd31);
    drain();
    set_step(REG_X_INV, '0);
    send_word(REQ_DEPOSIT, 26'h01_8000, 26'h01_8000, Q_ONE, '0, '0);
    drain();
    set_step(REG_X_INV, INV_RESET);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          xs = INV_RESET;
          ys = INV_RESET;
        end
        1: begin
          xs = 24'd1;
          ys = INV_MAX;
        end
        2: begin
          xs = INV_MAX;
          ys = 24'd1;
        end
        default: begin
          xs = $urandom_range(0, 1) ? INV_W'($urandom_range(8192, 262144))
                                    : INV_W'($urandom_range(1, INV_MAX));
          ys = $urandom_range(0, 1) ? INV_W'($urandom_range(8192, 262144))
                                    : INV_W'($urandom_range(1, INV_MAX));
        end
      endcase
      set_step(REG_X_INV, xs);
      set_step(REG_Y_INV, ys);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        random_word();
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("Covered %0d placed deposits, %0d dropped deposits and %0d node reads (%0d nonzero),",
             placed, dropped, reads, nonzero_reads);
    $display("with %0d grid clears and %0d register writes across %0d cell size settings.",
             clears, reg_writes, PHASES + 2);
    if (fail_count == 0 && owed == 0) begin
      $display("cic_charge_deposit_2d verification clean");
    end else begin
      $display("cic_charge_deposit_2d verification failed");
    end
    $finish;
  end

endmodule
